// ===== rtl/ecs_pkg.sv =====
// shared types, codes and helpers for the eight bit cpu subset executor
package ecs_pkg;

  localparam int unsigned MemDepthDefault = 65536;

  typedef enum logic [4:0] {
    K_MOV  = 5'd0,  K_STAX = 5'd1,  K_XCHG = 5'd2,  K_ADD  = 5'd3,
    K_DCR  = 5'd4,  K_INX  = 5'd5,  K_CMA  = 5'd6,  K_CMP  = 5'd7,
    K_DAD  = 5'd8,  K_SUB  = 5'd9,  K_MVI  = 5'd10, K_ADI  = 5'd11,
    K_SUI  = 5'd12, K_INR  = 5'd13, K_DCX  = 5'd14, K_LDA  = 5'd15,
    K_LHLD = 5'd16, K_STA  = 5'd17, K_LXI  = 5'd18, K_SHLD = 5'd19,
    K_JMP  = 5'd20, K_JC   = 5'd21, K_JNC  = 5'd22, K_JZ   = 5'd23,
    K_JNZ  = 5'd24, K_SET  = 5'd25, K_HLT  = 5'd26
  } kind_e;

  localparam logic [2:0] REG_A = 3'd0;
  localparam logic [2:0] REG_B = 3'd1;
  localparam logic [2:0] REG_C = 3'd2;
  localparam logic [2:0] REG_D = 3'd3;
  localparam logic [2:0] REG_E = 3'd4;
  localparam logic [2:0] REG_H = 3'd5;
  localparam logic [2:0] REG_L = 3'd6;

  typedef struct packed {
    logic s;
    logic z;
    logic ac;
    logic p;
    logic cy;
  } flags_t;

  typedef struct packed {
    logic [7:0] res;
    flags_t     flags;
  } alu_out_t;

  // even parity gives one
  function automatic logic parity_even(input logic [7:0] v);
    parity_even = ~(^v);
  endfunction

endpackage

// ===== rtl/ecs_ram.sv =====
// generic single write port ram with registered read
module ecs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ecs_alu.sv =====
// 8-bit add and subtract with the five flags
module ecs_alu (
  input  logic             [7:0] a_i,
  input  logic             [7:0] b_i,
  input  logic                   sub_i,
  output ecs_pkg::alu_out_t      out_o
);

  logic [7:0] bb;
  logic [8:0] sum;
  logic [4:0] nib;

  always_comb begin
    bb  = sub_i ? ~b_i : b_i;
    sum = {1'b0, a_i} + {1'b0, bb} + {8'd0, sub_i};
    nib = {1'b0, a_i[3:0]} + {1'b0, bb[3:0]} + {4'd0, sub_i};
    out_o.res      = sum[7:0];
    out_o.flags.cy = sub_i ? ~sum[8] : sum[8];
    out_o.flags.ac = nib[4];
    out_o.flags.s  = sum[7];
    out_o.flags.z  = (sum[7:0] == 8'd0);
    out_o.flags.p  = ecs_pkg::parity_even(sum[7:0]);
  end

endmodule

// ===== rtl/eight_bit_cpu_subset_execute.sv =====
// top level of the eight bit cpu subset executor
// Executes one decoded instruction per transfer against seven 8-bit
// registers, five flags, a 16-bit pc, a halt mark and a byte memory of
// MEM_DEPTH entries (a power of two; addresses are taken modulo the depth).
// An instruction is taken in the cycle its memory read is issued and executes
// from the execute register once the output register is free, so a new
// instruction can be accepted every cycle while results are taken; LHLD and
// SHLD need a second memory cycle for the high byte, as the memory has one
// read and one write port. A store in the execute cycle that hits the address
// being read is forwarded. Results sit in an output register, so the next
// instruction is taken while a result waits. After reset a clearing pass writes
// zero to every memory entry; no instruction is accepted until it ends.
module eight_bit_cpu_subset_execute #(
  parameter int unsigned MEM_DEPTH = ecs_pkg::MemDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // kind[4:0] dest_reg[7:5] source_reg[10:8] pair_select[12:11]
  // immediate[28:13] poke_data[36:29], zero fill
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // next_pc[15:0] halted[16] written_value[32:17] carry_flag[33]
  // zero_flag[34] sign_flag[35] parity_flag[36] aux_carry_flag[37], zero fill
  output logic [39:0] m_axis_tdata
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);

  // execute stage item
  logic        x_valid_q, x_valid_d;
  logic [4:0]  x_kind_q;
  logic [2:0]  x_dr_q, x_sr_q;
  logic [1:0]  x_ps_q;
  logic [15:0] x_imm_q;
  logic [7:0]  x_poke_q;
  logic        phase_q, phase_d;
  logic [7:0]  lo_q, lo_d;

  // architectural state
  logic [7:0]      rf_q [7];
  logic [7:0]      rf_d [7];
  ecs_pkg::flags_t fl_q, fl_d;
  logic [15:0]     pc_q, pc_d;
  logic            halt_q, halt_d;

  // memory and clearing pass
  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, ram_rdata, mem_rd;
  logic          re;
  logic          fwd_q;
  logic [7:0]    fwd_data_q;
  logic          x_we;
  logic [AW-1:0] x_waddr;
  logic [7:0]    x_wdata;

  // output register
  logic        m_valid_q, m_valid_d;
  logic [39:0] m_data_q;

  logic            s_fire, x_fire, out_free, need_two, phase0;
  logic [15:0]     imm_p1, wv;
  logic [7:0]      ra, rsrc, rdst;
  logic [15:0]     pair_v, hl_v;
  logic [7:0]      alu_b;
  logic            alu_sub;
  ecs_pkg::alu_out_t alu_o;

  function automatic logic [7:0] rd8(input logic [7:0] rf [7], input logic [2:0] i);
    rd8 = (i < 3'd7) ? rf[i] : 8'd0;
  endfunction

  function automatic logic [15:0] rdp(input logic [7:0] rf [7], input logic [1:0] p);
    logic [15:0] v;
    case (p)
      2'd0:    v = {rf[ecs_pkg::REG_B], rf[ecs_pkg::REG_C]};
      2'd1:    v = {rf[ecs_pkg::REG_D], rf[ecs_pkg::REG_E]};
      2'd2:    v = {rf[ecs_pkg::REG_H], rf[ecs_pkg::REG_L]};
      default: v = 16'd0;
    endcase
    rdp = v;
  endfunction

  assign out_free = !m_valid_q || m_axis_tready;
  assign need_two = !halt_q && ((ecs_pkg::kind_e'(x_kind_q) == ecs_pkg::K_LHLD) ||
                                (ecs_pkg::kind_e'(x_kind_q) == ecs_pkg::K_SHLD));
  assign phase0   = x_valid_q && need_two && !phase_q;
  assign x_fire   = x_valid_q && out_free && (!need_two || phase_q);
  assign s_axis_tready = !clr_q && (!x_valid_q || x_fire);
  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign imm_p1   = x_imm_q + 16'd1;

  // read port: incoming address, or the high byte of LHLD or SHLD
  assign re     = s_fire || phase0;
  assign raddr  = phase0 ? imm_p1[AW-1:0] : s_axis_tdata[13 +: AW];
  assign mem_rd = fwd_q ? fwd_data_q : ram_rdata;

  assign we    = clr_q || x_we;
  assign waddr = clr_q ? clr_cnt_q : x_waddr;
  assign wdata = clr_q ? 8'd0 : x_wdata;

  assign ra     = rf_q[ecs_pkg::REG_A];
  assign rsrc   = rd8(rf_q, x_sr_q);
  assign rdst   = rd8(rf_q, x_dr_q);
  assign pair_v = rdp(rf_q, x_ps_q);
  assign hl_v   = {rf_q[ecs_pkg::REG_H], rf_q[ecs_pkg::REG_L]};

  always_comb begin
    alu_b   = rsrc;
    alu_sub = 1'b0;
    case (ecs_pkg::kind_e'(x_kind_q))
      ecs_pkg::K_SUB, ecs_pkg::K_CMP: alu_sub = 1'b1;
      ecs_pkg::K_ADI: alu_b = x_imm_q[7:0];
      ecs_pkg::K_SUI: begin
        alu_b   = x_imm_q[7:0];
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  ecs_alu u_alu (
    .a_i  (ra),
    .b_i  (alu_b),
    .sub_i(alu_sub),
    .out_o(alu_o)
  );

  // execute: next state of registers, flags, pc and memory write
  always_comb begin
    logic [15:0] t16;
    logic [16:0] t17;
    logic [7:0]  n8;
    logic        jumped;
    logic [2:0]  len;
    rf_d    = rf_q;
    fl_d    = fl_q;
    halt_d  = halt_q;
    lo_d    = lo_q;
    wv      = 16'd0;
    jumped  = 1'b0;
    len     = 3'd1;
    x_we    = 1'b0;
    x_waddr = x_imm_q[AW-1:0];
    x_wdata = ra;
    t16     = 16'd0;
    t17     = 17'd0;
    n8      = 8'd0;
    if (phase0) begin
      lo_d = mem_rd;
      if (ecs_pkg::kind_e'(x_kind_q) == ecs_pkg::K_SHLD) begin
        x_we    = 1'b1;
        x_wdata = rf_q[ecs_pkg::REG_L];
      end
    end
    if (!halt_q) begin
      case (ecs_pkg::kind_e'(x_kind_q))
        ecs_pkg::K_MVI, ecs_pkg::K_ADI, ecs_pkg::K_SUI: len = 3'd2;
        ecs_pkg::K_LDA, ecs_pkg::K_LHLD, ecs_pkg::K_STA, ecs_pkg::K_LXI,
        ecs_pkg::K_SHLD, ecs_pkg::K_JMP, ecs_pkg::K_JC, ecs_pkg::K_JNC,
        ecs_pkg::K_JZ, ecs_pkg::K_JNZ: len = 3'd3;
        ecs_pkg::K_SET, ecs_pkg::K_HLT: len = 3'd4;
        default: len = 3'd1;
      endcase
      case (ecs_pkg::kind_e'(x_kind_q))
        ecs_pkg::K_MOV: begin
          wv = {8'd0, rsrc};
          if (x_dr_q < 3'd7) rf_d[x_dr_q] = rsrc;
        end
        ecs_pkg::K_STAX: begin
          wv = {8'd0, ra};
          x_we = x_fire;
          x_waddr = pair_v[AW-1:0];
        end
        ecs_pkg::K_XCHG: begin
          rf_d[ecs_pkg::REG_D] = rf_q[ecs_pkg::REG_H];
          rf_d[ecs_pkg::REG_E] = rf_q[ecs_pkg::REG_L];
          rf_d[ecs_pkg::REG_H] = rf_q[ecs_pkg::REG_D];
          rf_d[ecs_pkg::REG_L] = rf_q[ecs_pkg::REG_E];
          wv = {rf_q[ecs_pkg::REG_D], rf_q[ecs_pkg::REG_E]};
        end
        ecs_pkg::K_ADD, ecs_pkg::K_SUB, ecs_pkg::K_ADI, ecs_pkg::K_SUI: begin
          wv = {8'd0, alu_o.res};
          rf_d[ecs_pkg::REG_A] = alu_o.res;
          fl_d = alu_o.flags;
        end
        ecs_pkg::K_CMP: fl_d = alu_o.flags;
        ecs_pkg::K_DCR, ecs_pkg::K_INR: begin
          if (ecs_pkg::kind_e'(x_kind_q) == ecs_pkg::K_INR) begin
            n8 = rdst + 8'd1;
            fl_d.ac = (rdst[3:0] == 4'hF);
          end else begin
            n8 = rdst - 8'd1;
            fl_d.ac = (rdst[3:0] != 4'h0);
          end
          fl_d.s = n8[7];
          fl_d.z = (n8 == 8'd0);
          fl_d.p = ecs_pkg::parity_even(n8);
          if (x_dr_q < 3'd7) rf_d[x_dr_q] = n8;
          wv = {8'd0, n8};
        end
        ecs_pkg::K_INX, ecs_pkg::K_DCX, ecs_pkg::K_LXI: begin
          if (ecs_pkg::kind_e'(x_kind_q) == ecs_pkg::K_INX) t16 = pair_v + 16'd1;
          else if (ecs_pkg::kind_e'(x_kind_q) == ecs_pkg::K_DCX) t16 = pair_v - 16'd1;
          else t16 = x_imm_q;
          case (x_ps_q)
            2'd0: begin
              rf_d[ecs_pkg::REG_B] = t16[15:8];
              rf_d[ecs_pkg::REG_C] = t16[7:0];
            end
            2'd1: begin
              rf_d[ecs_pkg::REG_D] = t16[15:8];
              rf_d[ecs_pkg::REG_E] = t16[7:0];
            end
            2'd2: begin
              rf_d[ecs_pkg::REG_H] = t16[15:8];
              rf_d[ecs_pkg::REG_L] = t16[7:0];
            end
            default: t16 = (ecs_pkg::kind_e'(x_kind_q) == ecs_pkg::K_LXI) ? 16'd0 : t16;
          endcase
          wv = t16;
        end
        ecs_pkg::K_CMA: begin
          rf_d[ecs_pkg::REG_A] = ~ra;
          wv = {8'd0, ~ra};
        end
        ecs_pkg::K_DAD: begin
          t17 = {1'b0, pair_v} + {1'b0, hl_v};
          fl_d.cy = t17[16];
          rf_d[ecs_pkg::REG_H] = t17[15:8];
          rf_d[ecs_pkg::REG_L] = t17[7:0];
          wv = t17[15:0];
        end
        ecs_pkg::K_MVI: begin
          if (x_dr_q < 3'd7) rf_d[x_dr_q] = x_imm_q[7:0];
          wv = {8'd0, x_imm_q[7:0]};
        end
        ecs_pkg::K_LDA: begin
          rf_d[ecs_pkg::REG_A] = mem_rd;
          wv = {8'd0, mem_rd};
        end
        ecs_pkg::K_LHLD: begin
          rf_d[ecs_pkg::REG_L] = lo_q;
          rf_d[ecs_pkg::REG_H] = mem_rd;
          wv = {mem_rd, lo_q};
        end
        ecs_pkg::K_STA: begin
          wv = {8'd0, ra};
          x_we = x_fire;
        end
        ecs_pkg::K_SHLD: begin
          wv = hl_v;
          if (phase_q) begin
            x_we = x_fire;
            x_waddr = imm_p1[AW-1:0];
            x_wdata = rf_q[ecs_pkg::REG_H];
          end
        end
        ecs_pkg::K_JMP: jumped = 1'b1;
        ecs_pkg::K_JC:  jumped = fl_q.cy;
        ecs_pkg::K_JNC: jumped = !fl_q.cy;
        ecs_pkg::K_JZ:  jumped = fl_q.z;
        ecs_pkg::K_JNZ: jumped = !fl_q.z;
        ecs_pkg::K_SET: begin
          wv = {8'd0, x_poke_q};
          x_we = x_fire;
          x_wdata = x_poke_q;
        end
        ecs_pkg::K_HLT: halt_d = 1'b1;
        default: ;
      endcase
      pc_d = jumped ? x_imm_q : (pc_q + {13'd0, len});
    end else begin
      pc_d = pc_q;
    end
  end

  always_comb begin
    x_valid_d = x_valid_q;
    if (x_fire) x_valid_d = 1'b0;
    if (s_fire) x_valid_d = 1'b1;
    phase_d = phase_q;
    if (phase0) phase_d = 1'b1;
    if (x_fire) phase_d = 1'b0;
    m_valid_d = x_fire ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);
  end

  ecs_ram #(
    .WIDTH(8),
    .DEPTH(MEM_DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q <= 1'b0;
      phase_q   <= 1'b0;
      m_valid_q <= 1'b0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      fl_q      <= '0;
      pc_q      <= 16'd0;
      halt_q    <= 1'b0;
      fwd_q     <= 1'b0;
      for (int i = 0; i < 7; i++) rf_q[i] <= 8'd0;
    end else begin
      x_valid_q <= x_valid_d;
      phase_q   <= phase_d;
      m_valid_q <= m_valid_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(MEM_DEPTH - 1)) clr_q <= 1'b0;
      end
      if (re) fwd_q <= x_we && (x_waddr == raddr);
      if (x_fire) begin
        rf_q   <= rf_d;
        fl_q   <= fl_d;
        pc_q   <= pc_d;
        halt_q <= halt_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      x_kind_q <= s_axis_tdata[4:0];
      x_dr_q   <= s_axis_tdata[7:5];
      x_sr_q   <= s_axis_tdata[10:8];
      x_ps_q   <= s_axis_tdata[12:11];
      x_imm_q  <= s_axis_tdata[28:13];
      x_poke_q <= s_axis_tdata[36:29];
    end
    if (re) fwd_data_q <= x_wdata;
    lo_q <= lo_d;
    if (x_fire) begin
      m_data_q <= {2'b00, fl_d.ac, fl_d.p, fl_d.s, fl_d.z, fl_d.cy, wv, halt_d, pc_d};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // no instruction enters while the memory is being cleared
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s_axis_tready) else $error("accept during clearing pass");

  // second memory cycle of LHLD or SHLD holds off the next instruction
  a_phase_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase0 |-> !s_axis_tready) else $error("accept during second memory cycle");

  // a finished instruction always shows up as a result
  a_fire_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_fire |=> m_axis_tvalid) else $error("result lost");

  // halt mark is sticky until reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt mark cleared");

endmodule
